@@ rtl/assert_macros.svh @@
// Assertion macros shared by the scheduler RTL modules.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The condition holds in the same cycle as its trigger.
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// The condition holds in the cycle after its trigger.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

@@ rtl/prqs_pkg.sv @@
// Shared types and codes for the priority ready-queue scheduler.
package prqs_pkg;

	// Request modes.
	typedef enum logic [1:0] {
		MODE_ADD  = 2'd0,
		MODE_TICK = 2'd1,
		MODE_DROP = 2'd2
	} mode_t;

	// Result status codes.
	typedef enum logic [2:0] {
		ST_OK       = 3'd0,
		ST_BAD_PRIO = 3'd1,
		ST_FULL     = 3'd2,
		ST_EMPTY    = 3'd3,
		ST_NONE     = 3'd4
	} status_t;

	// Controller states.
	typedef enum logic [2:0] {
		S_IDLE,
		S_ADD,
		S_DROP,
		S_PUSH,
		S_PICK,
		S_LOAD,
		S_FINISH
	} state_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic latch;
		logic add;
		logic drop;
		logic push;
		logic pick;
		logic load;
	} cmd_t;

endpackage

@@ rtl/prqs_ctrl.sv @@
// Controller state machine that sequences each scheduler request.
`include "assert_macros.svh"

module prqs_ctrl (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           start,
	input  logic [1:0]     mode,
	output logic           busy,
	output logic           done,
	output prqs_pkg::cmd_t cmd
);
	import prqs_pkg::*;

	state_t state_q;
	state_t state_d;
	logic   accept;

	// A request is taken while idle or while the last result is shown.
	assign accept = start && ((state_q == S_IDLE) || (state_q == S_FINISH));

	// State register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Next state: a new request may enter while the last result is shown.
	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE, S_FINISH: begin
				if (accept) begin
					case (mode_t'(mode))
						MODE_ADD:  state_d = S_ADD;
						MODE_DROP: state_d = S_DROP;
						MODE_TICK: state_d = S_PUSH;
						default:   state_d = S_FINISH;
					endcase
				end else begin
					state_d = S_IDLE;
				end
			end
			S_ADD:   state_d = S_FINISH;
			S_DROP:  state_d = S_FINISH;
			S_PUSH:  state_d = S_PICK;
			S_PICK:  state_d = S_LOAD;
			S_LOAD:  state_d = S_FINISH;
			default: state_d = S_IDLE;
		endcase
	end

	// Outputs decoded from the state.
	always_comb begin
		busy      = !((state_q == S_IDLE) || (state_q == S_FINISH));
		done      = (state_q == S_FINISH);
		cmd.latch = accept;
		cmd.add   = (state_q == S_ADD);
		cmd.drop  = (state_q == S_DROP);
		cmd.push  = (state_q == S_PUSH);
		cmd.pick  = (state_q == S_PICK);
		cmd.load  = (state_q == S_LOAD);
	end

	`ASSERT_NEXT(a_accept_starts_work, clk, arst_n, accept, state_q != S_IDLE, "accepted request was dropped")
	`ASSERT_IMPLIES(a_finish_after_work, clk, arst_n, state_q == S_FINISH, ($past(state_q) != S_IDLE) || $past(accept), "result strobe without a request")

endmodule

@@ rtl/prqs_dp.sv @@
// Datapath: per-level queues, level bitmap, running task and tick counter.
`include "assert_macros.svh"

module prqs_dp #(
	parameter int NUM_LEVELS  = 32,
	parameter int QUEUE_DEPTH = 8
) (
	input  logic           clk,
	input  logic           arst_n,
	input  prqs_pkg::cmd_t cmd,
	input  logic [5:0]     levels_in_use,
	input  logic [5:0]     task_id,
	input  logic [4:0]     task_priority,
	output logic [2:0]     status,
	output logic [5:0]     running_task,
	output logic           running_valid,
	output logic [4:0]     running_priority,
	output logic           switched,
	output logic [31:0]    ready_levels,
	output logic [63:0]    tick_count
);
	import prqs_pkg::*;

	localparam int LW = (NUM_LEVELS > 1) ? $clog2(NUM_LEVELS) : 1;
	localparam int HW = $clog2(QUEUE_DEPTH);
	localparam int FW = $clog2(QUEUE_DEPTH + 1);
	localparam int SW = HW + 1;
	localparam int ENTRIES = NUM_LEVELS * QUEUE_DEPTH;
	localparam int AW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;

	logic [HW-1:0] head_q [NUM_LEVELS];
	logic [FW-1:0] fill_q [NUM_LEVELS];
	logic [31:0]   bitmap_q;
	logic [5:0]    cur_task_q;
	logic [4:0]    cur_lvl_q;
	logic          cur_valid_q;
	logic [63:0]   ticks_q;
	status_t       status_q;
	status_t       push_st_q;
	logic          switched_q;
	logic [5:0]    task_q;
	logic [4:0]    prio_q;
	logic [5:0]    mem [ENTRIES];
	logic [5:0]    rdata_q;

	logic [5:0]    en_n;
	logic [4:0]    top;
	logic          found;
	logic          hit;
	logic [4:0]    sel_prio;
	logic          sel_ok;
	logic [LW-1:0] sel_idx;
	logic [HW-1:0] head;
	logic [FW-1:0] fill;
	logic          full;
	logic          empty;
	logic [SW-1:0] sum;
	logic [HW-1:0] slot;
	logic [HW-1:0] head_nx;
	logic [AW-1:0] base;
	logic [AW-1:0] wr_addr;
	logic [AW-1:0] rd_addr;
	logic          enq;
	logic          deq;
	logic          wr_en;
	logic          rd_en;
	logic [5:0]    wr_data;
	status_t       enq_st;
	status_t       deq_st;

	// Enabled level count, clamped to the range 1 .. NUM_LEVELS.
	always_comb begin
		if (levels_in_use == 6'd0) begin
			en_n = 6'd1;
		end else if (levels_in_use > 6'(NUM_LEVELS)) begin
			en_n = 6'(NUM_LEVELS);
		end else begin
			en_n = levels_in_use;
		end
	end

	// Highest non-empty level.
	always_comb begin
		top = 5'd0;
		for (int i = 0; i < 32; i++) begin
			if (bitmap_q[i]) begin
				top = 5'(i);
			end
		end
		found = |bitmap_q;
		hit   = found && ({1'b0, top} < en_n);
	end

	// One level is addressed per cycle; its head and fill are read here.
	always_comb begin
		if (cmd.push) begin
			sel_prio = cur_lvl_q;
		end else if (cmd.pick) begin
			sel_prio = top;
		end else begin
			sel_prio = prio_q;
		end
		sel_ok  = ({1'b0, sel_prio} < en_n);
		sel_idx = sel_prio[LW-1:0];
		head    = head_q[sel_idx];
		fill    = fill_q[sel_idx];
		full    = (fill == FW'(QUEUE_DEPTH));
		empty   = (fill == '0);
		sum     = {1'b0, head} + SW'(fill);
		slot    = (sum >= SW'(QUEUE_DEPTH)) ? HW'(sum - SW'(QUEUE_DEPTH)) : sum[HW-1:0];
		head_nx = (head == HW'(QUEUE_DEPTH - 1)) ? '0 : head + HW'(1);
		base    = AW'(sel_idx) * AW'(QUEUE_DEPTH);
		wr_addr = base + AW'(slot);
		rd_addr = base + AW'(head);
	end

	// Queue operation decode.
	always_comb begin
		enq     = cmd.add || (cmd.push && cur_valid_q);
		deq     = cmd.drop || (cmd.pick && hit);
		wr_data = cmd.push ? cur_task_q : task_q;
		if (!sel_ok) begin
			enq_st = ST_BAD_PRIO;
			deq_st = ST_BAD_PRIO;
		end else begin
			enq_st = full ? ST_FULL : ST_OK;
			deq_st = empty ? ST_EMPTY : ST_OK;
		end
		wr_en = enq && (enq_st == ST_OK);
		rd_en = cmd.pick && hit;
	end

	// Task store: one write port, one registered read port.
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rdata_q <= mem[rd_addr];
		end
	end

	// Per-level head and fill counters and the level bitmap.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_LEVELS; i++) begin
				head_q[i] <= '0;
				fill_q[i] <= '0;
			end
			bitmap_q <= '0;
		end else if (wr_en) begin
			fill_q[sel_idx]    <= fill + FW'(1);
			bitmap_q[sel_prio] <= 1'b1;
		end else if (deq && (deq_st == ST_OK)) begin
			head_q[sel_idx] <= head_nx;
			fill_q[sel_idx] <= fill - FW'(1);
			if (fill == FW'(1)) begin
				bitmap_q[sel_prio] <= 1'b0;
			end
		end
	end

	// Running task, tick counter and result status.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_task_q  <= '0;
			cur_lvl_q   <= '0;
			cur_valid_q <= 1'b0;
			ticks_q     <= '0;
			status_q    <= ST_OK;
			push_st_q   <= ST_OK;
			switched_q  <= 1'b0;
		end else begin
			if (cmd.latch) begin
				status_q   <= ST_OK;
				switched_q <= 1'b0;
			end
			if (cmd.add) begin
				status_q <= enq_st;
			end
			if (cmd.drop) begin
				status_q <= deq_st;
			end
			if (cmd.push) begin
				push_st_q <= cur_valid_q ? enq_st : ST_OK;
			end
			if (cmd.pick) begin
				ticks_q <= ticks_q + 64'd1;
				if (hit) begin
					cur_lvl_q   <= top;
					cur_valid_q <= 1'b1;
					switched_q  <= 1'b1;
					status_q    <= push_st_q;
				end else begin
					cur_task_q  <= '0;
					cur_lvl_q   <= '0;
					cur_valid_q <= 1'b0;
					status_q    <= ST_NONE;
				end
			end
			if (cmd.load && cur_valid_q) begin
				cur_task_q <= rdata_q;
			end
		end
	end

	// Request fields held for the whole request.
	always_ff @(posedge clk) begin
		if (cmd.latch) begin
			task_q <= task_id;
			prio_q <= task_priority;
		end
	end

	assign status           = status_q;
	assign running_task     = cur_task_q;
	assign running_valid    = cur_valid_q;
	assign running_priority = cur_lvl_q;
	assign switched         = switched_q;
	assign ready_levels     = bitmap_q;
	assign tick_count       = ticks_q;

	`ASSERT_IMPLIES(a_idle_cur_zero, clk, arst_n, !cur_valid_q, (cur_task_q == 6'd0) && (cur_lvl_q == 5'd0), "idle running task not cleared")
	`ASSERT_NEXT(a_ticks_only_on_pick, clk, arst_n, !cmd.pick, $stable(ticks_q), "tick count moved outside a tick")
	`ASSERT_IMPLIES(a_bitmap_in_range, clk, arst_n, found, 32'(top) < 32'(NUM_LEVELS), "bitmap bit set beyond the last level")

endmodule

@@ rtl/priority_ready_queue_scheduler_unit.sv @@
// Top level of the priority ready-queue scheduler with its register port.
// Steps: an add or remove passes through its add or drop state, then the result
// state; an unused mode goes straight to the result; a tick passes through push
// back, pick and store read, load and result, as only one level's head and fill
// are addressed per cycle. The next request is taken in the result cycle; the
// receiver cannot stall. Reset clears queues, bitmap, running task
// and tick count at once; fill counts guard every store read, so no clear pass.
module priority_ready_queue_scheduler_unit #(
	parameter int NUM_LEVELS  = 32,
	parameter int QUEUE_DEPTH = 8
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [1:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,
	input  logic        start,
	input  logic [1:0]  mode,
	input  logic [5:0]  task_id,
	input  logic [4:0]  task_priority,
	output logic        busy,
	output logic        done,
	output logic [2:0]  status,
	output logic [5:0]  running_task,
	output logic        running_valid,
	output logic [4:0]  running_priority,
	output logic        switched,
	output logic [31:0] ready_levels,
	output logic [63:0] tick_count
);
	import prqs_pkg::*;

	localparam logic [1:0] ADDR_LEVELS = 2'd0;

	logic [5:0] levels_q;
	cmd_t       cmd;

	// Configuration register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			levels_q <= 6'd32;
		end else if (psel && penable && pwrite && (paddr == ADDR_LEVELS)) begin
			levels_q <= pwdata[5:0];
		end
	end

	assign pready = 1'b1;
	assign prdata = (paddr == ADDR_LEVELS) ? {26'd0, levels_q} : 32'd0;

	// Sequencer.
	prqs_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.mode   (mode),
		.busy   (busy),
		.done   (done),
		.cmd    (cmd)
	);

	// Queues and scheduling state.
	prqs_dp #(
		.NUM_LEVELS  (NUM_LEVELS),
		.QUEUE_DEPTH (QUEUE_DEPTH)
	) u_dp (
		.clk              (clk),
		.arst_n           (arst_n),
		.cmd              (cmd),
		.levels_in_use    (levels_q),
		.task_id          (task_id),
		.task_priority    (task_priority),
		.status           (status),
		.running_task     (running_task),
		.running_valid    (running_valid),
		.running_priority (running_priority),
		.switched         (switched),
		.ready_levels     (ready_levels),
		.tick_count       (tick_count)
	);

endmodule
